/* hw/rtl/fvnh_pkg.sv */
// Shared constants for the fractal value-noise height pipeline.
// Holds the hash multipliers, octave keys and the pipeline depth.
// No dependencies.
package fvnh_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 24;

  // lattice values are always Q0.24
  localparam int LATTICE_BITS = 24;

  localparam logic [63:0] HASH_MUL_X    = 64'h9E3779B185EBCA87;
  localparam logic [63:0] HASH_MUL_Z    = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_SEED_ADD = 64'h165667B19E3779F9;
  localparam logic [63:0] MIX_MUL_A     = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_MUL_B     = 64'hC4CEB9FE1A85EC53;
  localparam logic [63:0] OCTAVE1_KEY   = 64'h0000000012345678;
  localparam logic [63:0] OCTAVE2_KEY   = 64'h0000000087654321;

  // octave scales in hundredths
  localparam int SCALE0_HUNDREDTHS = 1;
  localparam int SCALE1_HUNDREDTHS = 5;
  localparam int SCALE2_HUNDREDTHS = 10;

  localparam int BASE_HEIGHT = 30;
  localparam int SUM_BITS    = 31;

  // register stages from input beat to output register
  localparam int PIPE_DEPTH  = 13;

endpackage

/* hw/rtl/fvnh_mul64.sv */
// Low 64 bits of a 64-bit operand times a 64-bit constant, two stages.
// Three 32x32 partial products are registered, then summed and registered.
// Depends on nothing.
module fvnh_mul64 #(
  parameter logic [63:0] MULT = 64'd1
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  output logic [63:0] p
);

  logic [63:0] prod_ll;
  logic [31:0] prod_lh;
  logic [31:0] prod_hl;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ll <= 64'(a[31:0] * MULT[31:0]);
      prod_lh <= 32'(a[31:0] * MULT[63:32]);
      prod_hl <= 32'(a[63:32] * MULT[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod_ll + {prod_lh + prod_hl, 32'd0};
    end
  end

endmodule

/* hw/rtl/fvnh_octave.sv */
// One octave of 2D value noise: scale, floor, smoothstep, four lattice
// hashes and a bilinear blend, twelve register stages long.
// Depends on fvnh_pkg and fvnh_mul64.
module fvnh_octave #(
  parameter int COORD_BITS    = fvnh_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = fvnh_pkg::FRACTION_BITS_DEF,
  parameter int HUNDREDTHS    = 1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic [63:0]                   key,
  output logic [fvnh_pkg::LATTICE_BITS-1:0] value
);
  import fvnh_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int PW = COORD_BITS + F + 1;
  localparam int LB = LATTICE_BITS;
  localparam longint unsigned ONE = 64'd1 << F;
  localparam logic [F-1:0] SCALE = F'((ONE * HUNDREDTHS + 50) / 100);
  localparam int SDLY = 8;

  // stage 1: scaled coordinates
  logic signed [PW-1:0] prod_x, prod_z;
  // stage 2: cells and fractions
  logic [63:0] cx0, cx1, cz0, cz1;
  logic [F-1:0] tx, tz;
  // stage 3: squared fractions
  logic [F-1:0] t2x, t2z, tx_d, tz_d;
  // stage 4 onward: smoothstep values, x in the upper half
  logic [2*F-1:0] s_pipe [SDLY];
  logic [2*F+1:0] ssx, ssz;
  // hash path
  logic [63:0] gx0, gx1, gz0, gz1;
  logic [63:0] kadd;
  logic [63:0] h1 [4];
  logic [63:0] h1_next [4];
  logic [63:0] ma [4];
  logic [63:0] mb [4];
  logic [LB-1:0] lat [4];
  logic [LB-1:0] row0, row1;
  logic [LB+F:0] row0_sum, row1_sum, v_sum;
  logic [F-1:0] sx_b, sz_b;

  always_ff @(posedge clk) begin
    kadd <= key + HASH_SEED_ADD;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= PW'(coord_x) * PW'(signed'({1'b0, SCALE}));
      prod_z <= PW'(coord_z) * PW'(signed'({1'b0, SCALE}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx0 <= 64'(prod_x >>> F);
      cx1 <= 64'(prod_x >>> F) + 64'd1;
      cz0 <= 64'(prod_z >>> F);
      cz1 <= 64'(prod_z >>> F) + 64'd1;
      tx  <= prod_x[F-1:0];
      tz  <= prod_z[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2x  <= F'((2*F)'(tx * tx) >> F);
      t2z  <= F'((2*F)'(tz * tz) >> F);
      tx_d <= tx;
      tz_d <= tz;
    end
  end

  always_comb begin
    ssx = (2*F+2)'(t2x * ((F+2)'(3 * ONE) - {1'b0, tx_d, 1'b0}));
    ssz = (2*F+2)'(t2z * ((F+2)'(3 * ONE) - {1'b0, tz_d, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_pipe[0] <= {ssx[2*F-1:F], ssz[2*F-1:F]};
      for (int i = 1; i < SDLY; i++) begin
        s_pipe[i] <= s_pipe[i-1];
      end
    end
  end

  // cell products, ready at stage 4
  fvnh_mul64 #(.MULT(HASH_MUL_X)) u_mx0 (.clk(clk), .en(en), .a(cx0), .p(gx0));
  fvnh_mul64 #(.MULT(HASH_MUL_X)) u_mx1 (.clk(clk), .en(en), .a(cx1), .p(gx1));
  fvnh_mul64 #(.MULT(HASH_MUL_Z)) u_mz0 (.clk(clk), .en(en), .a(cz0), .p(gz0));
  fvnh_mul64 #(.MULT(HASH_MUL_Z)) u_mz1 (.clk(clk), .en(en), .a(cz1), .p(gz1));

  // corner order: 00, 10, 01, 11
  always_comb begin
    logic [63:0] h [4];
    h[0] = gx0 ^ gz0 ^ kadd;
    h[1] = gx1 ^ gz0 ^ kadd;
    h[2] = gx0 ^ gz1 ^ kadd;
    h[3] = gx1 ^ gz1 ^ kadd;
    for (int i = 0; i < 4; i++) begin
      h1_next[i] = h[i] ^ (h[i] >> 33);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= h1_next;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_mix
    fvnh_mul64 #(.MULT(MIX_MUL_A)) u_ma (
      .clk(clk), .en(en), .a(h1[g]), .p(ma[g])
    );
    fvnh_mul64 #(.MULT(MIX_MUL_B)) u_mb (
      .clk(clk), .en(en), .a(ma[g] ^ (ma[g] >> 33)), .p(mb[g])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        lat[g] <= LB'(mb[g] ^ (mb[g] >> 33));
      end
    end
  end

  assign sx_b = s_pipe[SDLY-2][2*F-1:F];
  assign sz_b = s_pipe[SDLY-1][F-1:0];

  always_comb begin
    row0_sum = (LB+F+1)'(lat[0] * ((F+1)'(ONE) - {1'b0, sx_b}))
             + (LB+F+1)'(lat[1] * sx_b);
    row1_sum = (LB+F+1)'(lat[2] * ((F+1)'(ONE) - {1'b0, sx_b}))
             + (LB+F+1)'(lat[3] * sx_b);
    v_sum    = (LB+F+1)'(row0 * ((F+1)'(ONE) - {1'b0, sz_b}))
             + (LB+F+1)'(row1 * sz_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0  <= row0_sum[LB+F-1:F];
      row1  <= row1_sum[LB+F-1:F];
      value <= v_sum[LB+F-1:F];
    end
  end

endmodule

/* hw/rtl/fractal_value_noise_height.sv */
// Top level of the fractal value-noise height pipeline.
// Depends on fvnh_pkg and fvnh_octave.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------
//   input   | in_valid, in_stall  | coord_x, coord_z
//   output  | out_valid, out_stall| height_whole, height_fraction
//   config  | cfg_we              | cfg_data (noise_seed)
//
// One beat per cycle while the stages are not frozen (see below); the hash mix chain
// is built from the two-stage 64-bit multipliers.
// All stages advance together; they freeze only while the output register
// holds a beat and out_stall is high, and in_stall follows that condition.
// rst is synchronous and clears the valid bits and the seed.
module fractal_value_noise_height #(
  parameter int COORD_BITS    = fvnh_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = fvnh_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [6:0]                   height_whole,
  output logic [15:0]                  height_fraction
);
  import fvnh_pkg::*;

  logic [63:0] noise_seed;
  logic [PIPE_DEPTH-1:0] vld;
  logic en;
  logic [LATTICE_BITS-1:0] v0, v1, v2;
  logic [SUM_BITS-1:0] total;

  assign en        = !vld[PIPE_DEPTH-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= 64'd0;
    end else if (cfg_we) begin
      noise_seed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  fvnh_octave #(
    .COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
    .HUNDREDTHS(SCALE0_HUNDREDTHS)
  ) u_oct0 (
    .clk(clk), .en(en), .coord_x(coord_x), .coord_z(coord_z),
    .key(noise_seed), .value(v0)
  );

  fvnh_octave #(
    .COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
    .HUNDREDTHS(SCALE1_HUNDREDTHS)
  ) u_oct1 (
    .clk(clk), .en(en), .coord_x(coord_x), .coord_z(coord_z),
    .key(noise_seed ^ OCTAVE1_KEY), .value(v1)
  );

  fvnh_octave #(
    .COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
    .HUNDREDTHS(SCALE2_HUNDREDTHS)
  ) u_oct2 (
    .clk(clk), .en(en), .coord_x(coord_x), .coord_z(coord_z),
    .key(noise_seed ^ OCTAVE2_KEY), .value(v2)
  );

  // weights 32, 16, 8 on Q0.24 values, base in Q.24
  assign total = (SUM_BITS'(BASE_HEIGHT) << 24)
               + (SUM_BITS'(v0) << 5)
               + (SUM_BITS'(v1) << 4)
               + (SUM_BITS'(v2) << 3);

  always_ff @(posedge clk) begin
    if (en) begin
      height_whole    <= total[30:24];
      height_fraction <= total[23:8];
    end
  end

endmodule

/* hw/rtl/fvnh_checker.sv */
// Port-level checks for the fractal value-noise height pipeline.
// Bound to fractal_value_noise_height; depends on nothing else.
module fvnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  height_whole,
  input logic [15:0] height_fraction
);

  // a held output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(height_whole)
      && $stable(height_fraction))
    else $error("held output beat changed");

  // input stalls only because a finished beat waits downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting output beat");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> height_whole >= 7'd30 && height_whole <= 7'd85)
    else $error("height out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind fractal_value_noise_height fvnh_checker u_fvnh_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .height_whole(height_whole),
  .height_fraction(height_fraction)
);

/* tb/fvnh_height_checker.sv */
// Height checker for the fractal value-noise height block.
// Watches the config, coordinate and height channels, predicts each height and compares.
// Depends on fvnh_pkg for the hash constants and octave keys.
`timescale 1ns / 100ps

module fvnh_height_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  height_whole,
  input  logic [15:0] height_fraction,
  output int          fail_count,
  output int          pending_heights,
  output int          heights_checked
);
  import fvnh_pkg::*;

  localparam int FB = 24;
  localparam logic [63:0] FONE = 64'd1 << FB;

  typedef struct packed {
    logic [6:0]  whole;
    logic [15:0] fraction;
  } height_t;

  logic [63:0] seed_copy;
  height_t     expected_heights[$];

  function automatic logic [63:0] lattice_hash(logic [63:0] cx, logic [63:0] cz,
                                               logic [63:0] key);
    logic [63:0] h;
    h = cx * HASH_MUL_X;
    h ^= cz * HASH_MUL_Z;
    h ^= key + HASH_SEED_ADD;
    h ^= h >> 33;
    h = h * MIX_MUL_A;
    h ^= h >> 33;
    h = h * MIX_MUL_B;
    h ^= h >> 33;
    return h & 64'hFFFFFF;
  endfunction

  function automatic logic [63:0] ease(logic [63:0] t);
    logic [63:0] t2;
    t2 = (t * t) >> FB;
    return (t2 * (3 * FONE - 2 * t)) >> FB;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (FONE - s) + b * s) >> FB;
  endfunction

  function automatic logic [63:0] octave_noise(logic [63:0] x, logic [63:0] z,
                                               int hundredths, logic [63:0] key);
    logic [63:0] scale, px, pz, x0, z0, tx, tz, r0, r1;
    scale = (FONE * hundredths + 50) / 100;
    px = x * scale;
    pz = z * scale;
    x0 = $signed(px) >>> FB;
    z0 = $signed(pz) >>> FB;
    tx = ease(px & (FONE - 1));
    tz = ease(pz & (FONE - 1));
    r0 = mix(lattice_hash(x0, z0, key), lattice_hash(x0 + 1, z0, key), tx);
    r1 = mix(lattice_hash(x0, z0 + 1, key), lattice_hash(x0 + 1, z0 + 1, key), tx);
    return mix(r0, r1, tz);
  endfunction

  function automatic height_t predict_height(logic [31:0] cx, logic [31:0] cz,
                                            logic [63:0] seed);
    logic [63:0] x, z, total;
    height_t res;
    x = {{32{cx[31]}}, cx};
    z = {{32{cz[31]}}, cz};
    total = (64'd30 << 24) + 32 * octave_noise(x, z, SCALE0_HUNDREDTHS, seed)
          + 16 * octave_noise(x, z, SCALE1_HUNDREDTHS, seed ^ OCTAVE1_KEY)
          + 8 * octave_noise(x, z, SCALE2_HUNDREDTHS, seed ^ OCTAVE2_KEY);
    total = total >> 8;
    res.whole = total[22:16];
    res.fraction = total[15:0];
    return res;
  endfunction

  assign pending_heights = expected_heights.size();

  always @(posedge clk) begin
    height_t exp_h;
    if (rst) begin
      seed_copy <= '0;
      fail_count <= 0;
      heights_checked <= 0;
      expected_heights.delete();
    end else begin
      if (cfg_we) seed_copy <= cfg_data;
      if (in_valid && !in_stall)
        expected_heights = {expected_heights,
                            predict_height(coord_x, coord_z, seed_copy)};
      if (out_valid && !out_stall) begin
        heights_checked <= heights_checked + 1;
        if (expected_heights.size() == 0) begin
          $display("%0t: height beat with nothing expected, got %0d.%05d", $time,
                   height_whole, height_fraction);
          fail_count <= fail_count + 1;
        end else begin
          exp_h = expected_heights.pop_front();
          if (exp_h.whole !== height_whole || exp_h.fraction !== height_fraction) begin
            $display("%0t: height mismatch expected %0d/%0d actual %0d/%0d", $time,
                     exp_h.whole, exp_h.fraction, height_whole, height_fraction);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/tb_fractal_value_noise_height.sv */
// Testbench top for the fractal value-noise height block.
// Drives coordinates and seeds, varies output back-pressure, reports the verdict.
// Depends on fvnh_pkg, fvnh_height_checker and the block itself.
`timescale 1ns / 100ps

module tb_fractal_value_noise_height;
  import fvnh_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic signed [31:0] coord_x = '0, coord_z = '0;
  logic out_valid, out_stall = 0;
  logic [6:0] height_whole;
  logic [15:0] height_fraction;
  int fail_count, pending_heights, heights_checked;
  bit quiet_mode = 0;
  bit hold_off = 0;
  int coords_sent = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  fractal_value_noise_height DUT (.*);

  fvnh_height_checker checker_i (.*);

  // receiver: random stalls, a long hold-off when asked, none in quiet mode
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else if (quiet_mode) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < 27);
  end

  // leaves in_valid high after the beat; the caller drops it when done
  task automatic send_coord(logic [31:0] x, logic [31:0] z);
    if (!quiet_mode)
      while ($urandom_range(99) < 27) begin
        in_valid <= 0;
        @(negedge clk);
      end
    coord_x <= x;
    coord_z <= z;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    coords_sent++;
  endtask

  task automatic drain_heights();
    while (pending_heights != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic load_seed(logic [63:0] seed);
    drain_heights();
    cfg_data <= seed;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(4000) - 2000;
      2: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
      default: return 32'h8000_0000 + $urandom_range(200) - 100;
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_coord(pick_coord(), pick_coord());
    in_valid <= 0;
  endtask

  logic [31:0] edges[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'd99, 32'hFFFF_FF9C, 32'd100};

  initial begin
    repeat (11) @(negedge clk);
    rst <= 0;
    // edge coordinates, including negative floors, with the reset seed
    for (int i = 0; i < 8; i++) send_coord(edges[i], edges[7 - i]);
    send_coord(32'h5555_5555, 32'hAAAA_AAAA);
    send_coord(32'hAAAA_AAAA, 32'h5555_5555);
    in_valid <= 0;
    load_seed(64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++) send_coord(edges[i], edges[i]);
    in_valid <= 0;
    load_seed(64'h0);
    random_burst(400);
    load_seed({$urandom, $urandom});
    // fill the pipe against a held receiver
    fork
      begin
        hold_off = 1;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      random_burst(40);
    join
    drain_heights();
    quiet_mode = 1;
    random_burst(300);
    quiet_mode = 0;
    load_seed(64'hFFFF_FFFF_FFFF_FFFF);
    random_burst(400);
    load_seed({$urandom, $urandom});
    random_burst(480);
    drain_heights();
    $display("Sent %0d coordinates over six seed settings, %0d heights checked.",
             coords_sent, heights_checked);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
